@@ src/htf_pkg.sv @@
// Shared types and constants for the homogeneous point transform.
// No dependencies; every other file of the block but htf_stream_if imports this package.
package htf_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned NUM_REGS      = 8;
  localparam int unsigned REG_W         = 64;
  localparam int unsigned ADDR_W        = 6;
  localparam int unsigned SUM_W         = 66;
  localparam int unsigned QUOT_W        = 33;

  typedef logic signed [31:0] entry_t;
  typedef entry_t [3:0][3:0] mat_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               w_zero;
    logic               overflow;
  } result_t;

  typedef struct packed {
    logic [QUOT_W-1:0] mag;
    logic              neg;
    logic              big;
  } quot_t;

endpackage

@@ src/htf_stream_if.sv @@
// Valid/ready stream interface carrying one word of a parameterised payload type.
// Depends on nothing; the payload type is given at instantiation.
interface htf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ src/htf_cfg.sv @@
// APB register file holding the 4x4 matrix, two Q entries per 64-bit register.
// Depends on htf_pkg.
module htf_cfg #(
  parameter int unsigned FRAC_BITS = htf_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [htf_pkg::ADDR_W-1:0] paddr,
  input  logic [htf_pkg::REG_W-1:0]  pwdata,
  output logic [htf_pkg::REG_W-1:0]  prdata,
  output htf_pkg::mat_t              mat_o
);
  import htf_pkg::*;

  localparam logic [REG_W-1:0] One = REG_W'(1) << FRAC_BITS;

  logic [REG_W-1:0] cfg_q [NUM_REGS];
  logic [2:0]       idx;

  assign idx    = paddr[ADDR_W-1:3];
  assign prdata = cfg_q[idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[0] <= One;
      cfg_q[1] <= '0;
      cfg_q[2] <= One << 32;
      cfg_q[3] <= '0;
      cfg_q[4] <= '0;
      cfg_q[5] <= One;
      cfg_q[6] <= '0;
      cfg_q[7] <= One << 32;
    end else if (psel && penable && pwrite) begin
      cfg_q[idx] <= pwdata;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        mat_o[r][c] = cfg_q[r*2 + c/2][(c%2)*32 +: 32];
      end
    end
  end

endmodule

@@ src/htf_dot_lane.sv @@
// One column of the row-vector product: three products plus translation, then an exact sum floored.
// Depends on htf_pkg.
module htf_dot_lane #(
  parameter int unsigned FRAC_BITS = htf_pkg::FRAC_BITS_DEF,
  localparam int unsigned ColW     = htf_pkg::SUM_W - FRAC_BITS
) (
  input  logic                   clk_i,
  input  logic [1:0]             en_i,
  input  htf_pkg::point_t        point_i,
  input  htf_pkg::entry_t [3:0]  col_i,
  output logic signed [ColW-1:0] dot_o
);
  import htf_pkg::*;

  logic signed [63:0]      prod_q [3];
  logic signed [31:0]      trans_q;
  logic signed [SUM_W-1:0] sum;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q[0] <= point_i.point_x * col_i[0];
      prod_q[1] <= point_i.point_y * col_i[1];
      prod_q[2] <= point_i.point_z * col_i[2];
      trans_q   <= col_i[3];
    end
  end

  always_comb begin
    sum = SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]) + SUM_W'(prod_q[2])
        + (SUM_W'(trans_q) <<< FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      dot_o <= ColW'(sum >>> FRAC_BITS);
    end
  end

endmodule

@@ src/htf_div_lane.sv @@
// Pipelined restoring divider giving floor(|n| * 2^FRAC_BITS / |w|), one bit a stage.
// Depends on htf_pkg.
module htf_div_lane #(
  parameter int unsigned FRAC_BITS = htf_pkg::FRAC_BITS_DEF,
  localparam int unsigned ColW     = htf_pkg::SUM_W - FRAC_BITS,
  localparam int unsigned NStages  = htf_pkg::QUOT_W + 1
) (
  input  logic                   clk_i,
  input  logic [NStages-1:0]     en_i,
  input  logic signed [ColW-1:0] num_i,
  input  logic signed [ColW-1:0] den_i,
  output htf_pkg::quot_t         quot_o
);
  import htf_pkg::*;

  localparam int unsigned CmpW = SUM_W + QUOT_W;

  logic [SUM_W-1:0]  rem_q [NStages];
  logic [ColW-1:0]   den_q [NStages];
  logic [QUOT_W-1:0] quo_q [NStages];
  logic              neg_q [NStages];
  logic              big_q [NStages];

  logic [ColW-1:0]  un;
  logic [ColW-1:0]  uw;
  logic [SUM_W-1:0] dvd;

  always_comb begin
    un  = num_i[ColW-1] ? ColW'(-num_i) : ColW'(num_i);
    uw  = den_i[ColW-1] ? ColW'(-den_i) : ColW'(den_i);
    dvd = SUM_W'(un) << FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= dvd;
      den_q[0] <= uw;
      quo_q[0] <= '0;
      neg_q[0] <= num_i[ColW-1] ^ den_i[ColW-1];
      big_q[0] <= (dvd >> QUOT_W) >= SUM_W'(uw);
    end
  end

  for (genvar j = 1; j < NStages; j++) begin : g_step
    localparam int unsigned Bit = QUOT_W - j;
    logic [CmpW-1:0] sub;
    logic            take;

    always_comb begin
      sub  = CmpW'(den_q[j-1]) << Bit;
      take = CmpW'(rem_q[j-1]) >= sub;
    end

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j] <= take ? SUM_W'(CmpW'(rem_q[j-1]) - sub) : rem_q[j-1];
        den_q[j] <= den_q[j-1];
        quo_q[j] <= quo_q[j-1] | (QUOT_W'(take) << Bit);
        neg_q[j] <= neg_q[j-1];
        big_q[j] <= big_q[j-1];
      end
    end
  end

  assign quot_o.mag = quo_q[NStages-1];
  assign quot_o.neg = neg_q[NStages-1];
  assign quot_o.big = big_q[NStages-1];

endmodule

@@ src/homogeneous_point_transform.sv @@
// Top level: point x 4x4 matrix, then x', y', z' divided by w' and saturated.
// Stages in order: multiply, sum, divide setup, one per quotient bit, and merge.
// Throughput one word per cycle while out_o.ready holds; a stage holds its word only while the next is full and held.
// Reset clears all stage valid bits and loads the identity matrix.
// Depends on htf_pkg, htf_stream_if, htf_cfg, htf_dot_lane and htf_div_lane.
module homogeneous_point_transform #(
  parameter int unsigned FRAC_BITS = htf_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [htf_pkg::ADDR_W-1:0] paddr,
  input  logic [htf_pkg::REG_W-1:0]  pwdata,
  output logic [htf_pkg::REG_W-1:0]  prdata,
  output logic                       pready,
  htf_stream_if.sink                 in_i,
  htf_stream_if.source               out_o
);
  import htf_pkg::*;

  localparam int unsigned ColW   = SUM_W - FRAC_BITS;
  localparam int unsigned DivN   = QUOT_W + 1;
  localparam int unsigned NS     = DivN + 3;
  localparam int unsigned MergeS = NS - 1;

  mat_t                   mat;
  logic [NS-1:0]          vld_q;
  logic [NS:0]            en;
  logic signed [ColW-1:0] dot [4];
  quot_t                  quot [3];
  logic                   wz_q [DivN];
  logic                   sat [3];
  logic signed [31:0]     val [3];
  result_t                res_q;

  assign pready = 1'b1;

  htf_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .mat_o(mat)
  );

  assign en[NS] = out_o.ready;
  for (genvar s = 0; s < NS; s++) begin : g_en
    assign en[s] = !vld_q[s] || en[s+1];
  end
  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (en[s]) begin
          vld_q[s] <= (s == 0) ? in_i.valid : vld_q[s-1];
        end
      end
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_dot
    htf_dot_lane #(.FRAC_BITS(FRAC_BITS)) u_dot (
      .clk_i,
      .en_i   (en[1:0]),
      .point_i(in_i.payload),
      .col_i  ({mat[3][c], mat[2][c], mat[1][c], mat[0][c]}),
      .dot_o  (dot[c])
    );
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    htf_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i,
      .en_i  (en[DivN+1:2]),
      .num_i (dot[c]),
      .den_i (dot[3]),
      .quot_o(quot[c])
    );
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < DivN; j++) begin
      if (en[j+2]) begin
        wz_q[j] <= (j == 0) ? (dot[3] == '0) : wz_q[j-1];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (quot[c].neg) begin
        sat[c] = quot[c].big || (quot[c].mag > QUOT_W'(33'h0_8000_0000));
        val[c] = sat[c] ? 32'sh8000_0000 : 32'(-quot[c].mag);
      end else begin
        sat[c] = quot[c].big || (quot[c].mag > QUOT_W'(33'h0_7FFF_FFFF));
        val[c] = sat[c] ? 32'sh7FFF_FFFF : 32'(quot[c].mag);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[MergeS]) begin
      res_q.w_zero   <= wz_q[DivN-1];
      res_q.overflow <= !wz_q[DivN-1] && (sat[0] || sat[1] || sat[2]);
      res_q.out_x    <= wz_q[DivN-1] ? '0 : val[0];
      res_q.out_y    <= wz_q[DivN-1] ? '0 : val[1];
      res_q.out_z    <= wz_q[DivN-1] ? '0 : val[2];
    end
  end

  assign out_o.valid   = vld_q[MergeS];
  assign out_o.payload = res_q;

endmodule

@@ sim/tb_homogeneous_point_transform.sv @@
// Self-checking testbench for homogeneous_point_transform: points are streamed
// through the block under several matrices and each result word is checked.
// Depends on htf_pkg, htf_stream_if and the block's RTL.
module tb_homogeneous_point_transform;
  timeunit 1ns;
  timeprecision 1ps;
  import htf_pkg::*;

  localparam int unsigned LATENCY     = 37;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [REG_W-1:0]    pwdata = '0;
  logic [REG_W-1:0]    prdata;
  logic                pready;

  htf_stream_if #(.payload_t(point_t))  point_bus ();
  htf_stream_if #(.payload_t(result_t)) result_bus ();

  homogeneous_point_transform DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_i      (point_bus),
    .out_o     (result_bus)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [63:0] matrix_regs [NUM_REGS];
  point_t      points_pending [$];
  result_t     results_expected [$];
  bit          point_taken = 1'b0;
  bit          result_taken = 1'b0;
  bit          bursty = 1'b1;
  bit          long_hold = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned mismatches = 0;
  int unsigned points_sent = 0;
  int unsigned results_checked = 0;
  int unsigned wzero_seen = 0;
  int unsigned overflow_seen = 0;
  int unsigned cycles = 0;

  initial begin
    point_bus.valid   = 1'b0;
    point_bus.payload = '0;
    result_bus.ready  = 1'b0;
  end

  function automatic logic signed [127:0] entry_of(int r, int c);
    logic [63:0] reg_val;
    logic signed [31:0] e;
    reg_val = matrix_regs[r * 2 + c / 2];
    e = (c % 2) ? reg_val[63:32] : reg_val[31:0];
    return e;
  endfunction

  function automatic result_t transform_point(point_t p);
    logic signed [127:0] coord [3];
    logic signed [127:0] col [4];
    logic signed [127:0] acc, w, n, an, aw, mag;
    logic [31:0] q;
    result_t r;
    bit neg;
    coord[0] = p.point_x;
    coord[1] = p.point_y;
    coord[2] = p.point_z;
    for (int c = 0; c < 4; c++) begin
      acc = entry_of(3, c) <<< 16;
      for (int k = 0; k < 3; k++) acc = acc + coord[k] * entry_of(k, c);
      col[c] = acc >>> 16;
    end
    r = '0;
    w = col[3];
    if (w == 0) begin
      r.w_zero = 1'b1;
    end else begin
      for (int c = 0; c < 3; c++) begin
        n = col[c];
        neg = (n < 0) != (w < 0);
        an = (n < 0) ? -n : n;
        aw = (w < 0) ? -w : w;
        mag = (an <<< 16) / aw;
        if (neg) begin
          if (mag > 128'sh80000000) begin
            r.overflow = 1'b1;
            q = 32'h80000000;
          end else begin
            q = 32'(-mag);
          end
        end else if (mag > 128'sh7FFFFFFF) begin
          r.overflow = 1'b1;
          q = 32'h7FFFFFFF;
        end else begin
          q = 32'(mag);
        end
        case (c)
          0: r.out_x = q;
          1: r.out_y = q;
          default: r.out_z = q;
        endcase
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch on %s: got %08h, expected %08h (word %0d)", field, got, want,
             results_checked);
  endtask

  always @(posedge clk_i) begin
    point_taken  <= point_bus.valid && point_bus.ready;
    result_taken <= result_bus.valid && result_bus.ready;
    if (rst_ni && point_bus.valid && point_bus.ready) begin
      results_expected.push_back(transform_point(point_bus.payload));
      points_sent++;
    end
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (results_expected.size() == 0) begin
        report_mismatch("unexpected word", 32'(result_bus.payload), '0);
      end else begin
        result_t want, got;
        want = results_expected.pop_front();
        got  = result_bus.payload;
        if (got.out_x !== want.out_x) report_mismatch("out_x", got.out_x, want.out_x);
        if (got.out_y !== want.out_y) report_mismatch("out_y", got.out_y, want.out_y);
        if (got.out_z !== want.out_z) report_mismatch("out_z", got.out_z, want.out_z);
        if (got.w_zero !== want.w_zero) report_mismatch("w_zero", got.w_zero, want.w_zero);
        if (got.overflow !== want.overflow)
          report_mismatch("overflow", got.overflow, want.overflow);
        wzero_seen    += want.w_zero;
        overflow_seen += want.overflow;
      end
      results_checked++;
    end
  end

  always @(negedge clk_i) begin
    logic   v;
    point_t p;
    bit     load;
    if (rst_ni) begin
      v = point_bus.valid;
      load = 1'b0;
      if (v && point_taken) v = 1'b0;
      if (!v) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (points_pending.size() > 0) begin
          p = points_pending.pop_front();
          v = 1'b1;
          load = 1'b1;
          send_gap = bursty ? $urandom_range(0, 9) : 0;
        end
      end
      point_bus.valid <= v;
      if (load) point_bus.payload <= p;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (result_taken) recv_stall = bursty ? $urandom_range(0, 9) : 0;
      else if (recv_stall > 0) recv_stall--;
      result_bus.ready <= !long_hold && recv_stall == 0;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(int idx, logic [63:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 8);
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    matrix_regs[idx] = value;
  endtask

  task automatic wait_idle();
    while (points_pending.size() > 0 || point_bus.valid || results_expected.size() > 0)
      @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_entry(int mode);
    case (mode)
      0: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      1: return $urandom();
      default: return ($urandom_range(0, 1)) ? 32'h7FFFFFFF : 32'h80000000;
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    int mode;
    mode = $urandom_range(0, 3);
    p.point_x = (mode == 0) ? rand_entry(1) : rand_entry(0) * 8;
    p.point_y = (mode == 0) ? rand_entry(1) : rand_entry(0) * 8;
    p.point_z = (mode == 0) ? rand_entry(1) : rand_entry(0) * 8;
    return p;
  endfunction

  task automatic load_matrix(int mode);
    for (int i = 0; i < NUM_REGS; i++)
      write_reg(i, {rand_entry(mode), rand_entry(mode)});
  endtask

  task automatic queue_random(int count);
    repeat (count) points_pending.push_back(rand_point());
  endtask

  initial begin
    matrix_regs[0] = 64'h0000_0000_0001_0000;
    matrix_regs[1] = '0;
    matrix_regs[2] = 64'h0001_0000_0000_0000;
    matrix_regs[3] = '0;
    matrix_regs[4] = '0;
    matrix_regs[5] = 64'h0000_0000_0001_0000;
    matrix_regs[6] = '0;
    matrix_regs[7] = 64'h0001_0000_0000_0000;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    points_pending.push_back('{32'sh0, 32'sh0, 32'sh0});
    points_pending.push_back('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF});
    points_pending.push_back('{-32'sh80000000, -32'sh80000000, -32'sh80000000});
    points_pending.push_back('{32'sh00010000, -32'sh00010000, 32'sh00008000});
    points_pending.push_back('{32'shFFFFFFFF, 32'sh1, 32'sh7FFFFFFF});
    queue_random(40);
    wait_idle();

    // Perspective matrix: w' = z', so z at zero gives w_zero and small z overflows.
    write_reg(5, 64'h0001_0000_0001_0000);
    write_reg(7, '0);
    points_pending.push_back('{32'sh00050000, 32'sh00030000, 32'sh0});
    points_pending.push_back('{32'sh7FFFFFFF, -32'sh80000000, 32'sh1});
    points_pending.push_back('{-32'sh80000000, 32'sh7FFFFFFF, -32'sh1});
    points_pending.push_back('{32'sh00010000, 32'sh00020000, 32'sh00020000});
    points_pending.push_back('{32'sh00010000, -32'sh00020000, -32'sh00040000});
    queue_random(60);
    wait_idle();

    // All-zero matrix: every point has w' zero.
    for (int i = 0; i < NUM_REGS; i++) write_reg(i, '0);
    queue_random(20);
    wait_idle();

    // All-ones register contents: every entry is the smallest negative step.
    for (int i = 0; i < NUM_REGS; i++) write_reg(i, '1);
    queue_random(30);
    wait_idle();

    for (int phase = 0; phase < 10; phase++) begin
      bursty = (phase % 3) != 1;
      load_matrix(phase < 6 ? 0 : (phase < 9 ? 1 : 2));
      if (phase == 4) begin
        fork
          begin
            @(posedge clk_i);
            long_hold = 1'b1;
            repeat (400) @(posedge clk_i);
            long_hold = 1'b0;
          end
        join_none
      end
      queue_random(65);
      wait_idle();
    end

    $display("checked %0d result words from %0d points over 14 matrix settings",
             results_checked, points_sent);
    $display("w_zero results: %0d, saturated results: %0d", wzero_seen, overflow_seen);
    if (mismatches == 0 && results_expected.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
